@@ design/pvr_pkg.sv @@
package pvr_pkg;

  typedef logic signed [15:0] q14_t;
  typedef logic signed [31:0] q16_t;
  typedef logic signed [32:0] pos_t;

  typedef struct packed {
    logic en;
    logic vld;
  } pvr_ctl_t;

  typedef enum logic [2:0] {
    REG_OFF_X,
    REG_OFF_Y,
    REG_OFF_Z,
    REG_CAL_W,
    REG_CAL_X,
    REG_CAL_Y,
    REG_CAL_Z
  } cfg_reg_e;

  localparam int DivSteps  = 31;
  localparam int SqrtSteps = 16;
  localparam int NormLat   = DivSteps + SqrtSteps + 3;
  localparam int Q2mLat    = NormLat + 2;

  localparam q14_t OneQ14 = 16'sd16384;

  // round half up to q1.14 and clamp to 16 bits
  function automatic q14_t rnd_sat16(input logic signed [33:0] v);
    logic signed [33:0] t;
    logic signed [19:0] sh;
    t  = v + 34'sd8192;
    sh = 20'(t >>> 14);
    if (sh > 20'sd32767) begin
      return 16'sh7fff;
    end else if (sh < -20'sd32768) begin
      return 16'sh8000;
    end
    return q14_t'(sh);
  endfunction

endpackage

@@ design/pose_to_vr_space_matrix_unit.sv @@
// Camera pose to VR-space [R|t] matrix.
// Input channel (in_valid_i/in_ready_o): one pose per beat, position in
// q15.16 and a rotation quaternion in q1.14 that need not be unit length.
// Output channel (out_valid_o/out_ready_i): one 3x4 row-major matrix per
// beat, rotation in q1.14, translation in q15.16 saturated.
// Config channel (cfg_valid_i/cfg_ready_o): index 0..2 calibration offset,
// 3..6 calibration quaternion w,x,y,z; always ready, write only while idle.
// The quaternion to matrix pipeline holds a one-bit-a-stage divider, a
// one-bit-a-stage square root and stages for squaring, products and
// matrix assembly, and the combine follows it. Throughput is one beat
// per cycle unless the output stalls; every stage is pipelined.
// The calibration matrix comes from a second, free-running copy of the
// same pipeline fed from the config registers.
// Reset clears all valid bits, offsets to zero and calibration to identity.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and in_ready_o drops; nothing is lost or repeated.
module pose_to_vr_space_matrix_unit (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  pvr_pkg::q16_t        in_pos_x_i,
  input  pvr_pkg::q16_t        in_pos_y_i,
  input  pvr_pkg::q16_t        in_pos_z_i,
  input  pvr_pkg::q14_t        in_quat_w_i,
  input  pvr_pkg::q14_t        in_quat_x_i,
  input  pvr_pkg::q14_t        in_quat_y_i,
  input  pvr_pkg::q14_t        in_quat_z_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output pvr_pkg::q14_t        rot_00_o,
  output pvr_pkg::q14_t        rot_01_o,
  output pvr_pkg::q14_t        rot_02_o,
  output pvr_pkg::q16_t        out_pos_x_o,
  output pvr_pkg::q14_t        rot_10_o,
  output pvr_pkg::q14_t        rot_11_o,
  output pvr_pkg::q14_t        rot_12_o,
  output pvr_pkg::q16_t        out_pos_y_o,
  output pvr_pkg::q14_t        rot_20_o,
  output pvr_pkg::q14_t        rot_21_o,
  output pvr_pkg::q14_t        rot_22_o,
  output pvr_pkg::q16_t        out_pos_z_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [2:0]           cfg_index_i,
  input  logic [31:0]          cfg_data_i
);
  import pvr_pkg::*;

  q16_t      off_q [3];
  q14_t      cal_q [4];
  q14_t      cam_quat [4];
  pvr_ctl_t  ctl;
  pvr_ctl_t  cal_ctl;
  pvr_ctl_t  comb_ctl;
  logic      en;
  logic      cam_vld;
  q14_t      cam_mat [9];
  q14_t      cal_mat [9];
  pos_t      pdl_q [Q2mLat][3];
  q14_t      rot [9];
  q16_t      pos [3];

  assign en          = ~out_valid_o | out_ready_i;
  assign in_ready_o  = en;
  assign cfg_ready_o = 1'b1;
  assign ctl         = '{en: en, vld: in_valid_i & en};
  assign cal_ctl     = '{en: 1'b1, vld: 1'b1};
  assign comb_ctl    = '{en: en, vld: cam_vld};

  always_comb begin
    cam_quat[0] = in_quat_w_i;
    cam_quat[1] = in_quat_x_i;
    cam_quat[2] = in_quat_y_i;
    cam_quat[3] = in_quat_z_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) off_q[i] <= '0;
      cal_q[0] <= OneQ14;
      cal_q[1] <= '0;
      cal_q[2] <= '0;
      cal_q[3] <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_OFF_X: off_q[0] <= q16_t'(cfg_data_i);
        REG_OFF_Y: off_q[1] <= q16_t'(cfg_data_i);
        REG_OFF_Z: off_q[2] <= q16_t'(cfg_data_i);
        REG_CAL_W: cal_q[0] <= q14_t'(cfg_data_i[15:0]);
        REG_CAL_X: cal_q[1] <= q14_t'(cfg_data_i[15:0]);
        REG_CAL_Y: cal_q[2] <= q14_t'(cfg_data_i[15:0]);
        REG_CAL_Z: cal_q[3] <= q14_t'(cfg_data_i[15:0]);
        default: ;
      endcase
    end
  end

  // position delay matched to the matrix pipeline, y and z negated on entry
  always_ff @(posedge clk_i) begin
    if (en) begin
      pdl_q[0][0] <= 33'(in_pos_x_i);
      pdl_q[0][1] <= -33'(in_pos_y_i);
      pdl_q[0][2] <= -33'(in_pos_z_i);
      for (int s = 1; s < Q2mLat; s++) pdl_q[s] <= pdl_q[s-1];
    end
  end

  pvr_quat2mat u_cam (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (ctl),
    .quat_i  (cam_quat),
    .valid_o (cam_vld),
    .mat_o   (cam_mat)
  );

  pvr_quat2mat u_cal (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (cal_ctl),
    .quat_i  (cal_q),
    .valid_o (),
    .mat_o   (cal_mat)
  );

  pvr_combine u_comb (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (comb_ctl),
    .a_i     (cam_mat),
    .c_i     (cal_mat),
    .pos_i   (pdl_q[Q2mLat-1]),
    .off_i   (off_q),
    .valid_o (out_valid_o),
    .rot_o   (rot),
    .pos_o   (pos)
  );

  assign rot_00_o    = rot[0];
  assign rot_01_o    = rot[1];
  assign rot_02_o    = rot[2];
  assign rot_10_o    = rot[3];
  assign rot_11_o    = rot[4];
  assign rot_12_o    = rot[5];
  assign rot_20_o    = rot[6];
  assign rot_21_o    = rot[7];
  assign rot_22_o    = rot[8];
  assign out_pos_x_o = pos[0];
  assign out_pos_y_o = pos[1];
  assign out_pos_z_o = pos[2];

endmodule

@@ design/pvr_norm.sv @@
module pvr_norm (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  pvr_pkg::pvr_ctl_t  ctl_i,
  input  pvr_pkg::q14_t      quat_i [4],
  output logic               valid_o,
  output pvr_pkg::q14_t      quat_o [4]
);
  import pvr_pkg::*;

  // squares
  logic        sq_vld_q;
  logic [30:0] sq_q [4];
  logic        sq_sgn_q [4];

  // restoring division sq * 2^30 / s, one quotient bit per stage
  logic        dv_vld_q  [DivSteps+1];
  logic [33:0] dv_rem_q  [DivSteps+1][4];
  logic [30:0] dv_quo_q  [DivSteps+1][4];
  logic [32:0] dv_s_q    [DivSteps+1];
  logic        dv_sgn_q  [DivSteps+1][4];
  logic        dv_zero_q [DivSteps+1];
  logic [33:0] dv_rem_d  [1:DivSteps][4];
  logic [30:0] dv_quo_d  [1:DivSteps][4];

  // integer square root, one root bit per stage
  logic        sr_vld_q  [1:SqrtSteps];
  logic [31:0] sr_rad_q  [1:SqrtSteps][4];
  logic [15:0] sr_rt_q   [1:SqrtSteps][4];
  logic [19:0] sr_rm_q   [1:SqrtSteps][4];
  logic        sr_sgn_q  [1:SqrtSteps][4];
  logic        sr_zero_q [1:SqrtSteps];
  logic [31:0] sr_rad_d  [1:SqrtSteps][4];
  logic [15:0] sr_rt_d   [1:SqrtSteps][4];
  logic [19:0] sr_rm_d   [1:SqrtSteps][4];

  q14_t        quat_d [4];

  always_comb begin
    logic [33:0] t;
    logic [33:0] sx;
    logic        ge;
    for (int k = 1; k <= DivSteps; k++) begin
      for (int c = 0; c < 4; c++) begin
        t  = (k == 1) ? dv_rem_q[k-1][c] : {dv_rem_q[k-1][c][32:0], 1'b0};
        sx = {1'b0, dv_s_q[k-1]};
        ge = (t >= sx);
        dv_rem_d[k][c] = ge ? t - sx : t;
        dv_quo_d[k][c] = {dv_quo_q[k-1][c][29:0], ge};
      end
    end
  end

  always_comb begin
    logic [31:0] rad;
    logic [15:0] rt;
    logic [19:0] rm;
    logic [19:0] rem;
    logic [19:0] trial;
    logic        ge;
    for (int j = 1; j <= SqrtSteps; j++) begin
      for (int c = 0; c < 4; c++) begin
        if (j == 1) begin
          rad = {1'b0, dv_quo_q[DivSteps][c]};
          rt  = '0;
          rm  = '0;
        end else begin
          rad = sr_rad_q[j-1][c];
          rt  = sr_rt_q[j-1][c];
          rm  = sr_rm_q[j-1][c];
        end
        rem   = {rm[17:0], rad[31:30]};
        trial = {2'b00, rt, 2'b01};
        ge    = (rem >= trial);
        sr_rm_d[j][c]  = ge ? rem - trial : rem;
        sr_rt_d[j][c]  = {rt[14:0], ge};
        sr_rad_d[j][c] = {rad[29:0], 2'b00};
      end
    end
  end

  always_comb begin
    logic [16:0] lo;
    for (int c = 0; c < 4; c++) begin
      lo = {1'b0, sr_rt_q[SqrtSteps][c]} + 17'd1;
      if (sr_zero_q[SqrtSteps]) begin
        quat_d[c] = (c == 0) ? OneQ14 : '0;
      end else if (sr_sgn_q[SqrtSteps][c]) begin
        quat_d[c] = -q14_t'(lo[16:1]);
      end else begin
        quat_d[c] = q14_t'(lo[16:1]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_vld_q <= 1'b0;
      for (int k = 0; k <= DivSteps; k++) dv_vld_q[k] <= 1'b0;
      for (int j = 1; j <= SqrtSteps; j++) sr_vld_q[j] <= 1'b0;
      valid_o <= 1'b0;
    end else if (ctl_i.en) begin
      sq_vld_q    <= ctl_i.vld;
      dv_vld_q[0] <= sq_vld_q;
      for (int k = 1; k <= DivSteps; k++) dv_vld_q[k] <= dv_vld_q[k-1];
      sr_vld_q[1] <= dv_vld_q[DivSteps];
      for (int j = 2; j <= SqrtSteps; j++) sr_vld_q[j] <= sr_vld_q[j-1];
      valid_o <= sr_vld_q[SqrtSteps];
    end
  end

  always_ff @(posedge clk_i) begin
    logic signed [31:0] prod;
    if (ctl_i.en) begin
      for (int c = 0; c < 4; c++) begin
        prod        = quat_i[c] * quat_i[c];
        sq_q[c]     <= prod[30:0];
        sq_sgn_q[c] <= quat_i[c][15];
      end
      dv_s_q[0]    <= 33'(sq_q[0]) + 33'(sq_q[1]) + 33'(sq_q[2]) + 33'(sq_q[3]);
      dv_zero_q[0] <= ~|{sq_q[0], sq_q[1], sq_q[2], sq_q[3]};
      for (int c = 0; c < 4; c++) begin
        dv_rem_q[0][c] <= 34'(sq_q[c]);
        dv_quo_q[0][c] <= '0;
        dv_sgn_q[0][c] <= sq_sgn_q[c];
      end
      for (int k = 1; k <= DivSteps; k++) begin
        dv_s_q[k]    <= dv_s_q[k-1];
        dv_zero_q[k] <= dv_zero_q[k-1];
        for (int c = 0; c < 4; c++) begin
          dv_rem_q[k][c] <= dv_rem_d[k][c];
          dv_quo_q[k][c] <= dv_quo_d[k][c];
          dv_sgn_q[k][c] <= dv_sgn_q[k-1][c];
        end
      end
      for (int j = 1; j <= SqrtSteps; j++) begin
        sr_zero_q[j] <= (j == 1) ? dv_zero_q[DivSteps] : sr_zero_q[j-1];
        for (int c = 0; c < 4; c++) begin
          sr_rad_q[j][c] <= sr_rad_d[j][c];
          sr_rt_q[j][c]  <= sr_rt_d[j][c];
          sr_rm_q[j][c]  <= sr_rm_d[j][c];
          sr_sgn_q[j][c] <= (j == 1) ? dv_sgn_q[DivSteps][c] : sr_sgn_q[j-1][c];
        end
      end
      for (int c = 0; c < 4; c++) quat_o[c] <= quat_d[c];
    end
  end

endmodule

@@ design/pvr_quat2mat.sv @@
module pvr_quat2mat (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  pvr_pkg::pvr_ctl_t  ctl_i,
  input  pvr_pkg::q14_t      quat_i [4],
  output logic               valid_o,
  output pvr_pkg::q14_t      mat_o [9]
);
  import pvr_pkg::*;

  logic               nrm_vld;
  q14_t               nrm [4];
  logic               pr_vld_q;
  logic signed [31:0] xx_q, yy_q, zz_q, xy_q, xz_q, yz_q, wx_q, wy_q, wz_q;
  logic signed [31:0] r [9];

  pvr_norm u_norm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (ctl_i),
    .quat_i  (quat_i),
    .valid_o (nrm_vld),
    .quat_o  (nrm)
  );

  always_comb begin
    logic signed [31:0] one;
    one  = 32'sd268435456;
    r[0] = one - 2 * (yy_q + zz_q);
    r[1] = 2 * (xy_q - wz_q);
    r[2] = 2 * (xz_q + wy_q);
    r[3] = 2 * (xy_q + wz_q);
    r[4] = one - 2 * (xx_q + zz_q);
    r[5] = 2 * (yz_q - wx_q);
    r[6] = 2 * (xz_q - wy_q);
    r[7] = 2 * (yz_q + wx_q);
    r[8] = one - 2 * (xx_q + yy_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pr_vld_q <= 1'b0;
      valid_o  <= 1'b0;
    end else if (ctl_i.en) begin
      pr_vld_q <= nrm_vld;
      valid_o  <= pr_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en) begin
      xx_q <= nrm[1] * nrm[1];
      yy_q <= nrm[2] * nrm[2];
      zz_q <= nrm[3] * nrm[3];
      xy_q <= nrm[1] * nrm[2];
      xz_q <= nrm[1] * nrm[3];
      yz_q <= nrm[2] * nrm[3];
      wx_q <= nrm[0] * nrm[1];
      wy_q <= nrm[0] * nrm[2];
      wz_q <= nrm[0] * nrm[3];
      for (int i = 0; i < 9; i++) mat_o[i] <= rnd_sat16(34'(r[i]));
    end
  end

endmodule

@@ design/pvr_combine.sv @@
module pvr_combine (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  pvr_pkg::pvr_ctl_t  ctl_i,
  input  pvr_pkg::q14_t      a_i [9],
  input  pvr_pkg::q14_t      c_i [9],
  input  pvr_pkg::pos_t      pos_i [3],
  input  pvr_pkg::q16_t      off_i [3],
  output logic               valid_o,
  output pvr_pkg::q14_t      rot_o [9],
  output pvr_pkg::q16_t      pos_o [3]
);
  import pvr_pkg::*;

  logic               s1_vld_q, s2_vld_q;
  logic signed [31:0] cp_q [3][3][3];
  logic signed [48:0] pp_q [3][3];
  q14_t               rot2_q [9];
  logic signed [36:0] pr_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      valid_o  <= 1'b0;
    end else if (ctl_i.en) begin
      s1_vld_q <= ctl_i.vld;
      s2_vld_q <= s1_vld_q;
      valid_o  <= s2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    logic signed [31:0] prod;
    logic signed [33:0] e;
    logic signed [50:0] ps;
    logic signed [37:0] v;
    if (ctl_i.en) begin
      // camera rows 1 and 2 enter negated
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          for (int k = 0; k < 3; k++) begin
            prod = c_i[i*3+k] * a_i[k*3+j];
            cp_q[i][j][k] <= (k == 0) ? prod : -prod;
          end
        end
        for (int k = 0; k < 3; k++) begin
          pp_q[i][k] <= 49'(c_i[i*3+k]) * 49'(pos_i[k]);
        end
      end
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          e = 34'(cp_q[i][j][0]) + 34'(cp_q[i][j][1]) + 34'(cp_q[i][j][2]);
          rot2_q[i*3+j] <= rnd_sat16(e);
        end
        ps = 51'(pp_q[i][0]) + 51'(pp_q[i][1]) + 51'(pp_q[i][2]) + 51'sd8192;
        pr_q[i] <= 37'(ps >>> 14);
      end
      for (int i = 0; i < 9; i++) rot_o[i] <= rot2_q[i];
      for (int i = 0; i < 3; i++) begin
        v = 38'(pr_q[i]) + 38'(off_i[i]);
        if (v > 38'sd2147483647) begin
          pos_o[i] <= 32'sh7fffffff;
        end else if (v < -38'sd2147483648) begin
          pos_o[i] <= 32'sh80000000;
        end else begin
          pos_o[i] <= q16_t'(v);
        end
      end
    end
  end

endmodule

@@ design/pvr_chk.sv @@
module pvr_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [15:0] rot_00_o,
  input logic [15:0] rot_22_o,
  input logic [31:0] out_pos_x_o,
  input logic [31:0] out_pos_z_o
);

  // a waiting result beat is held
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("output beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(rot_00_o) && $stable(rot_22_o) &&
    $stable(out_pos_x_o) && $stable(out_pos_z_o))
    else $error("output payload changed while stalled");

  // pipeline freezes on a stall
  a_stall_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !in_ready_o)
    else $error("input taken while output stalled");

  // no back-pressure without a waiting result
  a_free_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input blocked with output empty");

endmodule

bind pose_to_vr_space_matrix_unit pvr_chk u_pvr_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .rot_00_o    (rot_00_o),
  .rot_22_o    (rot_22_o),
  .out_pos_x_o (out_pos_x_o),
  .out_pos_z_o (out_pos_z_o)
);
